// ===== hdl/sdog_pkg.sv =====
// Shared types, constants and the CRC-8 byte step of the OOK symbol generator.
// No dependencies; used by sdog_crc8 and the top level.
package sdog_pkg;

	// Transmission shape.
	localparam int REPEATS          = 4;
	localparam int PREAMBLE_SYMBOLS = 4;
	localparam int DATA_BITS        = 80;
	localparam int PAYLOAD_BITS     = DATA_BITS - 8;
	localparam int PAYLOAD_BYTES    = PAYLOAD_BITS / 8;

	// Counter widths follow from the shape above.
	localparam int POS_W   = $clog2(PREAMBLE_SYMBOLS + DATA_BITS + 1);
	localparam int BIT_W   = $clog2(DATA_BITS);
	localparam int FRAME_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;
	localparam int BYTE_CNT_W = $clog2(PAYLOAD_BYTES + 1);

	localparam logic [7:0] CRC_POLY = 8'h97;

	// Configuration registers.
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W   = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SYNC_HIGH = 3'd0,
		REG_SYNC_LOW  = 3'd1,
		REG_ZERO_HIGH = 3'd2,
		REG_ZERO_LOW  = 3'd3,
		REG_ONE_HIGH  = 3'd4,
		REG_ONE_LOW   = 3'd5,
		REG_GAP_HIGH  = 3'd6,
		REG_GAP_LOW   = 3'd7
	} reg_idx_t;

	localparam logic [15:0] REG_RESET [NUM_REGS] = '{
		16'd600, 16'd600, 16'd200, 16'd400, 16'd400, 16'd200, 16'd0, 16'd2000
	};

	// Input beat kinds.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	typedef enum logic [1:0] {
		SYM_SYNC = 2'd0,
		SYM_ZERO = 2'd1,
		SYM_ONE  = 2'd2,
		SYM_GAP  = 2'd3
	} sym_t;

	typedef struct packed {
		sym_t        symbol;
		logic [15:0] high_time_us;
		logic [15:0] low_time_us;
		logic        last;
	} result_t;

	// One byte of an MSB-first CRC-8 with no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/sensor_datagram_ook_symbol_generator_unit.sv =====
// OOK/PWM symbol generator for a ten-byte sensor datagram with CRC-8.
// Depends on sdog_pkg and instantiates sdog_crc8.
//
// Usage: the slave stream takes one beat per request. tuser selects the kind:
// a load beat (tuser 0) packs the reading in tdata into the datagram and
// restarts the transmission; a next beat (tuser 1) asks for one symbol.
// Each next beat while a transmission is active yields exactly one master
// beat: the symbol kind in tuser and its on/off times in tdata. A
// transmission is REPEATS frames of sync symbols and 80 data bits, most
// significant bit first, then one inter-message gap beat with tlast high.
// Load beats and next beats while idle produce no output beat.
// The output beat is registered from the accepted next beat. The block
// accepts one beat every cycle while the skid register is empty; state
// is updated on acceptance, so back-to-back requests need no extra spacing.
// A two-entry output stage (output register plus skid register) decouples
// the sides: when the receiver stalls, one more beat is still accepted, and
// tready drops only while the skid register is occupied.
// The CRC byte is computed one byte per cycle after a load, over nine bytes;
// it is first needed 76 requests later, so it is always ready in time.
// Reset clears the counters, the output stage and loads the default timing
// registers; the datagram holds no value until the first load.
module sensor_datagram_ook_symbol_generator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// Slave stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// tdata from bit 0: sensor_type[3:0], sensor_id[7:4], temp_one[19:8],
	// temp_two[31:20], hum_one[39:32], hum_two[47:40], pressure[63:48],
	// supply_code[71:64].
	input  logic [71:0]                 s_tdata,
	// tuser: action[0].
	input  logic                        s_tuser,
	// Master stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// tdata from bit 0: high_time_us[15:0], low_time_us[31:16].
	output logic [31:0]                 m_tdata,
	// tuser: symbol[1:0].
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sdog_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	// Timing registers.
	logic [15:0] regs_q [sdog_pkg::NUM_REGS];
	logic [sdog_pkg::REG_IDX_W-1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[sdog_pkg::ADDR_W-1:2];
	assign prdata  = {16'd0, regs_q[reg_sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdog_pkg::NUM_REGS; i++) begin
				regs_q[i] <= sdog_pkg::REG_RESET[i];
			end
		end else if (psel && penable && pwrite && pready) begin
			regs_q[reg_sel] <= pwdata[15:0];
		end
	end

	// Sequencer state.
	logic [sdog_pkg::PAYLOAD_BITS-1:0] dgram_q;
	logic [sdog_pkg::FRAME_W-1:0]      frame_q;
	logic [sdog_pkg::POS_W-1:0]        pos_q;
	logic                              active_q;

	logic        in_fire;
	logic        is_load;
	logic        is_next;
	logic [7:0]  crc;
	logic        crc_busy;
	logic [sdog_pkg::PAYLOAD_BITS-1:0] dgram_in;

	assign in_fire = s_tvalid && s_tready;
	assign is_load = in_fire && (s_tuser == sdog_pkg::ACT_LOAD);
	assign is_next = in_fire && (s_tuser == sdog_pkg::ACT_NEXT) && active_q;

	// The tdata fields are regrouped into datagram byte order, byte 0 in the
	// top bits: type and id nibbles, the two temperatures, humidities,
	// pressure and supply code.
	assign dgram_in = {s_tdata[3:0], s_tdata[7:4], s_tdata[19:8], s_tdata[31:20],
		s_tdata[39:32], s_tdata[47:40], s_tdata[63:48], s_tdata[71:64]};

	sdog_crc8 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (is_load),
		.data   (dgram_in),
		.crc    (crc),
		.busy   (crc_busy)
	);

	always_ff @(posedge clk) begin
		if (is_load) begin
			dgram_q <= dgram_in;
		end
	end

	// Symbol selection for the current position.
	logic [sdog_pkg::DATA_BITS-1:0] frame_bits;
	logic [sdog_pkg::POS_W-1:0]     data_idx;
	logic [sdog_pkg::BIT_W-1:0]     bit_sel;
	logic                           data_bit;
	logic                           in_preamble;
	logic                           in_gap;
	logic                           frame_end;
	logic                           more_frames;
	sdog_pkg::result_t              res;

	assign frame_bits  = {dgram_q, crc};
	assign data_idx    = pos_q - sdog_pkg::POS_W'(sdog_pkg::PREAMBLE_SYMBOLS);
	assign bit_sel     = sdog_pkg::BIT_W'(sdog_pkg::DATA_BITS - 1)
		- data_idx[sdog_pkg::BIT_W-1:0];
	assign data_bit    = frame_bits[bit_sel];
	assign in_preamble = pos_q < sdog_pkg::POS_W'(sdog_pkg::PREAMBLE_SYMBOLS);
	assign in_gap      = pos_q >= sdog_pkg::POS_W'(sdog_pkg::PREAMBLE_SYMBOLS
		+ sdog_pkg::DATA_BITS);
	assign frame_end   = pos_q == sdog_pkg::POS_W'(sdog_pkg::PREAMBLE_SYMBOLS
		+ sdog_pkg::DATA_BITS - 1);
	assign more_frames = ({1'b0, frame_q} + 1'b1)
		< (sdog_pkg::FRAME_W+1)'(sdog_pkg::REPEATS);

	always_comb begin
		res.last = 1'b0;
		if (in_preamble) begin
			res.symbol       = sdog_pkg::SYM_SYNC;
			res.high_time_us = regs_q[sdog_pkg::REG_SYNC_HIGH];
			res.low_time_us  = regs_q[sdog_pkg::REG_SYNC_LOW];
		end else if (in_gap) begin
			res.symbol       = sdog_pkg::SYM_GAP;
			res.high_time_us = regs_q[sdog_pkg::REG_GAP_HIGH];
			res.low_time_us  = regs_q[sdog_pkg::REG_GAP_LOW];
			res.last         = 1'b1;
		end else if (data_bit) begin
			res.symbol       = sdog_pkg::SYM_ONE;
			res.high_time_us = regs_q[sdog_pkg::REG_ONE_HIGH];
			res.low_time_us  = regs_q[sdog_pkg::REG_ONE_LOW];
		end else begin
			res.symbol       = sdog_pkg::SYM_ZERO;
			res.high_time_us = regs_q[sdog_pkg::REG_ZERO_HIGH];
			res.low_time_us  = regs_q[sdog_pkg::REG_ZERO_LOW];
		end
	end

	// Counter update. After the last bit of the last frame the position
	// simply runs on into the gap slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (is_load) begin
			frame_q  <= '0;
			pos_q    <= '0;
			active_q <= 1'b1;
		end else if (is_next) begin
			if (in_gap) begin
				frame_q  <= '0;
				pos_q    <= '0;
				active_q <= 1'b0;
			end else if (frame_end && more_frames) begin
				frame_q <= frame_q + 1'b1;
				pos_q   <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Output register with a skid register behind it.
	sdog_pkg::result_t out_q;
	sdog_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              out_pop;

	assign out_pop  = !out_valid_q || m_tready;
	assign s_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= is_next;
			end
		end else if (is_next) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (!out_pop && is_next) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.symbol;
	assign m_tdata  = {out_q.low_time_us, out_q.high_time_us};
	assign m_tlast  = out_q.last;

`ifndef SYNTHESIS
	// The CRC byte must be settled before any of its bits is sent.
	a_crc_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(is_next && (pos_q >= sdog_pkg::POS_W'(sdog_pkg::PREAMBLE_SYMBOLS
			+ sdog_pkg::PAYLOAD_BITS))) |-> !crc_busy)
		else $error("CRC byte read while still being computed");

	// The skid register is only ever filled behind a stalled output register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a beat while output register is empty");

	// Sending the gap symbol ends the transmission unless a load comes along.
	a_gap_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(is_next && in_gap) |=> !active_q)
		else $error("block still active after the final gap symbol");
`endif

endmodule

// ===== hdl/sdog_crc8.sv =====
// Byte-serial CRC-8 engine over the nine payload bytes of a datagram.
// Depends on sdog_pkg for the polynomial step and sizes.
module sdog_crc8 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sdog_pkg::PAYLOAD_BITS-1:0] data,
	output logic [7:0]                       crc,
	output logic                             busy
);

	logic [sdog_pkg::PAYLOAD_BITS-1:0] shift_q;
	logic [sdog_pkg::BYTE_CNT_W-1:0]   cnt_q;
	logic [7:0]                        crc_q;

	// The payload shifts out most significant byte first, one byte per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= '0;
		end else if (start) begin
			cnt_q <= sdog_pkg::BYTE_CNT_W'(sdog_pkg::PAYLOAD_BYTES);
			crc_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			crc_q <= sdog_pkg::crc8_byte(crc_q,
				shift_q[sdog_pkg::PAYLOAD_BITS-1 -: 8]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= data;
		end else if (cnt_q != '0) begin
			shift_q <= shift_q << 8;
		end
	end

	assign crc  = crc_q;
	assign busy = (cnt_q != '0);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the OOK symbol generator: streams load and next beats,
// predicts every symbol beat, and reprograms the timing registers over the APB port.
// Depends on sdog_pkg and sensor_datagram_ook_symbol_generator_unit.
module tb_top;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int CYCLE_LIMIT   = 600000;
	// Symbols of one whole transmission: every frame plus the closing gap.
	localparam int TX_SYMBOLS    = sdog_pkg::REPEATS
		* (sdog_pkg::PREAMBLE_SYMBOLS + sdog_pkg::DATA_BITS) + 1;
	// Output stage plus the CRC pass over nine bytes after a load, with margin.
	localparam int DRAIN_CYCLES  = 12;
	localparam int LONG_HOLD     = 300;
	localparam int DIR_ROWS      = 24;

	localparam logic [15:0] TIMING_AT_RESET [sdog_pkg::NUM_REGS] = '{
		16'd600, 16'd600, 16'd200, 16'd400, 16'd400, 16'd200, 16'd0, 16'd2000
	};

	// Laid out so that the packed vector is exactly the slave tdata word:
	// the last member lands in the lowest bits.
	typedef struct packed {
		logic [7:0]  supply_code;
		logic [15:0] pressure;
		logic [7:0]  hum_two;
		logic [7:0]  hum_one;
		logic [11:0] temp_two;
		logic [11:0] temp_one;
		logic [3:0]  sensor_id;
		logic [3:0]  sensor_type;
	} reading_t;

	// How a row of the directed list is checked.
	typedef enum logic [1:0] {
		CHK_PREDICTED,
		CHK_SILENT,
		CHK_TYPED
	} row_check_t;

	typedef struct packed {
		logic              act;
		reading_t          rd;
		row_check_t        chk;
		sdog_pkg::result_t typed;
	} stim_row_t;

	typedef enum int {
		TIMING_ZERO,
		TIMING_MAX,
		TIMING_RANDOM,
		TIMING_DEFAULT
	} timing_style_t;

	typedef enum int {
		RX_STREAM,
		RX_MOSTLY_READY,
		RX_MOSTLY_STALLED,
		RX_PERIODIC
	} rx_mode_t;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [71:0]                 s_tdata;
	logic                        s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [31:0]                 m_tdata;
	logic [1:0]                  m_tuser;
	logic                        m_tlast;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sdog_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	// Our own copy of the encoder: timing registers, the 80-bit datagram
	// (byte 0 in the top bits) and the symbol sequencing counters.
	logic [15:0] timing_us [sdog_pkg::NUM_REGS];
	logic [79:0] dgram_bits;
	int          frame_idx;
	int          sym_pos;
	bit          tx_active;

	// Symbol beats predicted but not yet seen on the master side, oldest first.
	sdog_pkg::result_t pending_symbols [$];

	stim_row_t   directed [DIR_ROWS];
	int          mismatches     = 0;
	int          beats_received = 0;
	int          random_items   = 0;
	int          burst_left     = 0;
	int          cycle_count    = 0;

	sensor_datagram_ook_symbol_generator_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// CRC-8 over the nine payload bytes, shifted in one bit at a time, MSB
	// first, starting from zero. Same result as the bytewise form.
	function automatic logic [7:0] datagram_crc(input logic [71:0] payload);
		logic [7:0] crc;
		logic       fb;
		crc = 8'h00;
		for (int i = 71; i >= 0; i--) begin
			fb  = crc[7] ^ payload[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? sdog_pkg::CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// Advances the encoder by one accepted beat. Returns 1 when the beat
	// produces a symbol, which is then left in sym_out.
	function automatic bit encoder_step(input logic act, input reading_t rd,
			output sdog_pkg::result_t sym_out);
		logic data_bit;
		sym_out = '0;
		if (act == sdog_pkg::ACT_LOAD) begin
			dgram_bits[79:8] = {rd.sensor_type, rd.sensor_id, rd.temp_one, rd.temp_two,
				rd.hum_one, rd.hum_two, rd.pressure, rd.supply_code};
			dgram_bits[7:0] = datagram_crc(dgram_bits[79:8]);
			frame_idx = 0;
			sym_pos   = 0;
			tx_active = 1'b1;
			return 1'b0;
		end
		// A next request with no transmission under way is simply dropped.
		if (!tx_active)
			return 1'b0;

		if (sym_pos < sdog_pkg::PREAMBLE_SYMBOLS) begin
			sym_out.symbol       = sdog_pkg::SYM_SYNC;
			sym_out.high_time_us = timing_us[sdog_pkg::REG_SYNC_HIGH];
			sym_out.low_time_us  = timing_us[sdog_pkg::REG_SYNC_LOW];
		end else if (sym_pos < sdog_pkg::PREAMBLE_SYMBOLS + sdog_pkg::DATA_BITS) begin
			data_bit = dgram_bits[sdog_pkg::DATA_BITS - 1
				- (sym_pos - sdog_pkg::PREAMBLE_SYMBOLS)];
			sym_out.symbol       = data_bit ? sdog_pkg::SYM_ONE : sdog_pkg::SYM_ZERO;
			sym_out.high_time_us = data_bit ? timing_us[sdog_pkg::REG_ONE_HIGH]
				: timing_us[sdog_pkg::REG_ZERO_HIGH];
			sym_out.low_time_us  = data_bit ? timing_us[sdog_pkg::REG_ONE_LOW]
				: timing_us[sdog_pkg::REG_ZERO_LOW];
		end else begin
			sym_out.symbol       = sdog_pkg::SYM_GAP;
			sym_out.high_time_us = timing_us[sdog_pkg::REG_GAP_HIGH];
			sym_out.low_time_us  = timing_us[sdog_pkg::REG_GAP_LOW];
			sym_out.last         = 1'b1;
		end

		// The gap ends the transmission. The last bit of a frame starts the
		// next frame, except in the final frame, where the position simply
		// moves on into the gap slot.
		if (sym_out.last) begin
			tx_active = 1'b0;
			frame_idx = 0;
			sym_pos   = 0;
		end else if (sym_pos + 1 == sdog_pkg::PREAMBLE_SYMBOLS + sdog_pkg::DATA_BITS
				&& frame_idx + 1 < sdog_pkg::REPEATS) begin
			frame_idx++;
			sym_pos = 0;
		end else begin
			sym_pos++;
		end
		return 1'b1;
	endfunction

	// Field values lean on the ends of the range now and then.
	function automatic logic [15:0] rand_field(input int width);
		logic [15:0] ones;
		ones = 16'((32'h1 << width) - 1);
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return ones;
			default: return 16'($urandom) & ones;
		endcase
	endfunction

	function automatic reading_t rand_reading();
		reading_t rd;
		rd.sensor_type = 4'(rand_field(4));
		rd.sensor_id   = 4'(rand_field(4));
		rd.temp_one    = 12'(rand_field(12));
		rd.temp_two    = 12'(rand_field(12));
		rd.hum_one     = 8'(rand_field(8));
		rd.hum_two     = 8'(rand_field(8));
		rd.pressure    = rand_field(16);
		rd.supply_code = 8'(rand_field(8));
		return rd;
	endfunction

	function automatic stim_row_t load_row(input logic [3:0] ty, input logic [3:0] id,
			input logic [11:0] t1, input logic [11:0] t2, input logic [7:0] h1,
			input logic [7:0] h2, input logic [15:0] pr, input logic [7:0] sc);
		stim_row_t row;
		row     = '0;
		row.act = sdog_pkg::ACT_LOAD;
		row.chk = CHK_SILENT;
		row.rd  = '{supply_code: sc, pressure: pr, hum_two: h2, hum_one: h1,
			temp_two: t2, temp_one: t1, sensor_id: id, sensor_type: ty};
		return row;
	endfunction

	// The payload of a next beat is ignored by the block, so it carries noise.
	function automatic stim_row_t next_row(input row_check_t chk, input sdog_pkg::sym_t sym,
			input logic [15:0] hi, input logic [15:0] lo, input logic last);
		stim_row_t row;
		row     = '0;
		row.act = sdog_pkg::ACT_NEXT;
		row.rd  = rand_reading();
		row.chk = chk;
		row.typed.symbol       = sym;
		row.typed.high_time_us = hi;
		row.typed.low_time_us  = lo;
		row.typed.last         = last;
		return row;
	endfunction

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offers one beat on the slave side and returns at the edge that takes it.
	// The sender runs in bursts; between bursts it drops tvalid for a random
	// gap, and a zero gap lets bursts run together into long unbroken stretches.
	task automatic send_beat(input logic act, input reading_t rd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= rd;
		do @(posedge clk); while (!s_tready);
	endtask

	// Sends one beat and queues whatever symbol the encoder copy predicts.
	// Next requests on an idle encoder do nothing and are not counted.
	task automatic drive_item(input logic act, input reading_t rd);
		sdog_pkg::result_t sym;
		send_beat(act, rd);
		if (encoder_step(act, rd, sym)) begin
			pending_symbols.push_back(sym);
			random_items++;
		end else if (act == sdog_pkg::ACT_LOAD) begin
			random_items++;
		end
	endtask

	// Parks the sender until every predicted symbol has come out, then waits
	// out the output stage and the CRC pass so the block is truly quiet.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_transfer(input logic wr, input sdog_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_timing_readback();
		logic [31:0] rdata;
		for (int r = 0; r < sdog_pkg::NUM_REGS; r++) begin
			apb_transfer(1'b0, sdog_pkg::reg_idx_t'(r), 32'h0, rdata);
			check_field($sformatf("register %0d", r), {16'h0000, timing_us[r]}, rdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Rewrites all eight timing registers with the block idle. The upper half
	// of pwdata carries noise, which the block must drop.
	task automatic reprogram_timing(input timing_style_t style);
		logic [31:0] wdata;
		logic [31:0] rdata;
		drain_results();
		for (int r = 0; r < sdog_pkg::NUM_REGS; r++) begin
			case (style)
				TIMING_ZERO:   wdata[15:0] = 16'h0000;
				TIMING_MAX:    wdata[15:0] = 16'hffff;
				TIMING_RANDOM: wdata[15:0] = rand_field(16);
				default:       wdata[15:0] = TIMING_AT_RESET[r];
			endcase
			wdata[31:16] = 16'($urandom);
			apb_transfer(1'b1, sdog_pkg::reg_idx_t'(r), wdata, rdata);
			timing_us[r] = wdata[15:0];
		end
		check_timing_readback();
	endtask

	// Symbol checker: every master beat is matched against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		sdog_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_received++;
			if (pending_symbols.size() == 0) begin
				$display({"%0t: symbol beat mismatch, expected none, ",
					"actual symbol %0d high %0d low %0d last %0d"},
					$time, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
				mismatches++;
			end else begin
				want = pending_symbols.pop_front();
				check_field("symbol", want.symbol, m_tuser);
				check_field("high_time_us", want.high_time_us, m_tdata[15:0]);
				check_field("low_time_us", want.low_time_us, m_tdata[31:16]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Receiver back-pressure. The stall pattern switches between a few modes
	// every so often. Twice in the run the receiver stops dead for a long
	// stretch while the sender keeps going, which fills the output stage and
	// must push back on the slave side.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		int       hold_marks [$];
		m_tready   = 1'b0;
		mode       = RX_STREAM;
		mode_left  = 0;
		tick       = 0;
		hold_marks = '{150, 900};
		wait (arst_n === 1'b1);
		forever begin
			if (hold_marks.size() != 0 && beats_received >= hold_marks[0]) begin
				void'(hold_marks.pop_front());
				repeat (LONG_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			@(negedge clk);
			case (mode)
				RX_STREAM:         m_tready <= 1'b1;
				RX_MOSTLY_READY:   m_tready <= ($urandom_range(3) != 0);
				RX_MOSTLY_STALLED: m_tready <= ($urandom_range(3) == 0);
				default:           m_tready <= (tick % 3 != 0);
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin
		int kind;
		int runs;
		int seq_idx;
		sdog_pkg::result_t sym;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = sdog_pkg::ACT_NEXT;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		timing_us  = TIMING_AT_RESET;
		dgram_bits = '0;
		frame_idx  = 0;
		sym_pos    = 0;
		tx_active  = 1'b0;

		// Directed list. Loads A and B between them drive every tdata bit to
		// both values (all-ones against all-zeros fields, most negative and most
		// positive temperatures). Typed rows run on the reset timing.
		directed = '{
			// Next request straight after reset: nothing to send yet.
			next_row(CHK_SILENT, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			// Load A: type 15, id 0, temps +2047 / -2048, extremes elsewhere.
			load_row(4'hf, 4'h0, 12'h7ff, 12'h800, 8'hff, 8'h00, 16'hffff, 8'h00),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			// Byte 0 is 0xf0, so the first data bit is a one.
			next_row(CHK_TYPED, sdog_pkg::SYM_ONE, 16'd400, 16'd200, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			// Load B in the middle of the data bits restarts the preamble.
			load_row(4'h0, 4'hf, 12'h800, 12'h7ff, 8'h00, 8'hff, 16'h0000, 8'hff),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			// Two loads back to back; only the second one counts.
			load_row(4'h5, 4'ha, 12'hfff, 12'h001, 8'h80, 8'h7f, 16'h8000, 8'haa),
			load_row(4'ha, 4'h5, 12'h000, 12'hfff, 8'h01, 8'hfe, 16'h0001, 8'h55),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_SYNC, 16'd600, 16'd600, 1'b0),
			// Byte 0 is now 0xa5: one, zero, one, ...
			next_row(CHK_TYPED, sdog_pkg::SYM_ONE, 16'd400, 16'd200, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_ZERO, 16'd200, 16'd400, 1'b0),
			next_row(CHK_TYPED, sdog_pkg::SYM_ONE, 16'd400, 16'd200, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0),
			next_row(CHK_PREDICTED, sdog_pkg::SYM_SYNC, 16'd0, 16'd0, 1'b0)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The timing registers must come out of reset at their defaults.
		check_timing_readback();

		foreach (directed[i]) begin
			send_beat(directed[i].act, directed[i].rd);
			case (directed[i].chk)
				CHK_PREDICTED: begin
					if (encoder_step(directed[i].act, directed[i].rd, sym))
						pending_symbols.push_back(sym);
				end
				CHK_SILENT: begin
					void'(encoder_step(directed[i].act, directed[i].rd, sym));
				end
				default: begin
					void'(encoder_step(directed[i].act, directed[i].rd, sym));
					pending_symbols.push_back(directed[i].typed);
				end
			endcase
		end

		// Random part. Half of the sequences on average are complete transmissions,
		// which reach the later frames, the frame wrap and the closing gap; a few
		// extra requests after the gap hit the idle encoder. The rest are cut short
		// by a fresh load or are loose load/next noise. The first two sequences
		// run on all-zero and all-ones timing.
		seq_idx = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (seq_idx == 0)
				reprogram_timing(TIMING_ZERO);
			else if (seq_idx == 1)
				reprogram_timing(TIMING_MAX);
			else if ($urandom_range(2) == 0)
				reprogram_timing(($urandom_range(3) == 0) ? TIMING_DEFAULT : TIMING_RANDOM);

			kind = $urandom_range(9);
			if (kind < 5) begin
				drive_item(sdog_pkg::ACT_LOAD, rand_reading());
				repeat (TX_SYMBOLS + $urandom_range(0, 2))
					drive_item(sdog_pkg::ACT_NEXT, rand_reading());
			end else if (kind < 8) begin
				runs = ($urandom_range(1) == 0) ? $urandom_range(0, 20)
					: $urandom_range(0, TX_SYMBOLS - 1);
				drive_item(sdog_pkg::ACT_LOAD, rand_reading());
				repeat (runs)
					drive_item(sdog_pkg::ACT_NEXT, rand_reading());
			end else begin
				repeat ($urandom_range(1, 6))
					drive_item(1'($urandom_range(1)), rand_reading());
			end
			seq_idx++;
		end

		drain_results();
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
